// ===== rtl/swled_pkg.sv =====
package swled_pkg;

    localparam int BYTE_W     = 8;
    localparam int SHORT_W    = 16;
    localparam int LONG_W     = 20;
    localparam int CNT_W      = 20;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam int BIT_POS_W  = 3;

    // Request codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RESET     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEAD      = 3'd5;

    // Register reset values
    localparam logic [SHORT_W-1:0] ONE_HIGH_RST  = 16'd35;
    localparam logic [SHORT_W-1:0] ONE_LOW_RST   = 16'd80;
    localparam logic [SHORT_W-1:0] ZERO_HIGH_RST = 16'd10;
    localparam logic [SHORT_W-1:0] ZERO_LOW_RST  = 16'd110;
    localparam logic [LONG_W-1:0]  RESET_RST     = 20'd6000;
    localparam logic [LONG_W-1:0]  LEAD_RST      = 20'd1000;

    localparam logic [BIT_POS_W-1:0] LAST_BIT_POS = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_HIGH,
        PH_LOW,
        PH_WAIT,
        PH_RESET
    } phase_t;

    // Classified request as it travels from front to back
    typedef struct packed {
        logic              is_push;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } req_t;

    typedef struct packed {
        logic pin_level;
        logic byte_accepted;
        logic holding_free;
        logic frame_done;
        logic busy_res;
    } result_t;

    typedef struct packed {
        logic [SHORT_W-1:0] one_high_ticks;
        logic [SHORT_W-1:0] one_low_ticks;
        logic [SHORT_W-1:0] zero_high_ticks;
        logic [SHORT_W-1:0] zero_low_ticks;
        logic [LONG_W-1:0]  reset_ticks;
        logic [LONG_W-1:0]  lead_ticks;
    } timing_t;

endpackage

// ===== rtl/swled_if.sv =====
interface swled_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [swled_pkg::BYTE_W-1:0] data_byte;
    logic                         last_byte;

    modport source (output valid, output cmd, output data_byte, output last_byte,
                    input ready);
    modport sink (input valid, input cmd, input data_byte, input last_byte,
                  output ready);
endinterface

interface swled_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic byte_accepted;
    logic holding_free;
    logic frame_done;
    logic busy_res;

    modport source (output valid, output pin_level, output byte_accepted,
                    output holding_free, output frame_done, output busy_res,
                    input ready);
    modport sink (input valid, input pin_level, input byte_accepted,
                  input holding_free, input frame_done, input busy_res,
                  output ready);
endinterface

// ===== rtl/swled_front.sv =====
module swled_front #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    swled_in_if.sink          in_ch,
    output logic              head_valid,
    output swled_pkg::req_t   head_req,
    input  logic              head_pop
);
    import swled_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    req_t              q_mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              push_en;
    logic              pop_en;
    req_t              in_req;

    // Classify the incoming request
    always_comb
    begin
        in_req.is_push   = (in_ch.cmd == CMD_PUSH);
        in_req.data_byte = in_ch.data_byte;
        in_req.last_byte = in_ch.last_byte;
    end

    assign in_ch.ready = (fill_reg < FILL_W'(DEPTH));
    assign push_en     = in_ch.valid && in_ch.ready;
    assign head_valid  = (fill_reg != '0);
    assign pop_en      = head_pop && head_valid;
    assign head_req    = q_mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push_en && pop_en)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the request in the queue
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// ===== rtl/swled_engine.sv =====
module swled_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  swled_pkg::timing_t timing,
    input  logic              head_valid,
    input  swled_pkg::req_t   head_req,
    output logic              head_pop,
    swled_out_if.source       out_ch
);
    import swled_pkg::*;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [BYTE_W-1:0]     shift_reg;
    logic [BYTE_W-1:0]     shift_next;
    logic [BIT_POS_W-1:0]  bit_pos_reg;
    logic [BIT_POS_W-1:0]  bit_pos_next;
    logic                  cur_last_reg;
    logic                  cur_last_next;
    logic [BYTE_W-1:0]     held_byte_reg;
    logic [BYTE_W-1:0]     held_byte_next;
    logic                  held_valid_reg;
    logic                  held_valid_next;
    logic                  held_last_reg;
    logic                  held_last_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_res_reg;
    result_t               out_res_next;

    logic                  cur_bit;
    logic [CNT_W:0]        cnt_inc;
    logic [CNT_W:0]        limit;
    logic                  reached;
    logic                  is_tick;

    // Take a request whenever the output slot frees this cycle
    assign head_pop = head_valid && (!out_valid_reg || out_ch.ready);
    assign is_tick  = !head_req.is_push;

    // Select the duration of the current phase
    always_comb
    begin
        cur_bit = shift_reg[LAST_BIT_POS - bit_pos_reg];
        cnt_inc = {1'b0, cnt_reg} + 1'b1;
        case (phase_reg)
            PH_HIGH:
            begin
                limit = (CNT_W + 1)'(cur_bit ? timing.one_high_ticks
                                             : timing.zero_high_ticks);
            end
            PH_LOW:
            begin
                limit = (CNT_W + 1)'(cur_bit ? timing.one_low_ticks
                                             : timing.zero_low_ticks);
            end
            PH_RESET:
            begin
                limit = (CNT_W + 1)'(timing.reset_ticks);
            end
            default:
            begin
                limit = (CNT_W + 1)'(timing.lead_ticks);
            end
        endcase
        // A zero duration lasts one tick, except the lead-in
        if (phase_reg != PH_LEAD && limit == '0)
        begin
            limit = (CNT_W + 1)'(1);
        end
        reached = (cnt_inc >= limit);
    end

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        shift_next      = shift_reg;
        bit_pos_next    = bit_pos_reg;
        cur_last_next   = cur_last_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_last_next  = held_last_reg;
        if (head_pop)
        begin
            if (!is_tick)
            begin
                // Fill the holding register; refuse when full
                if (!held_valid_reg)
                begin
                    held_byte_next  = head_req.data_byte;
                    held_last_next  = head_req.last_byte;
                    held_valid_next = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (held_valid_reg)
                        begin
                            shift_next      = held_byte_reg;
                            cur_last_next   = held_last_reg;
                            held_valid_next = 1'b0;
                            bit_pos_next    = '0;
                            cnt_next        = '0;
                            phase_next      = (timing.lead_ticks == '0) ? PH_HIGH : PH_LEAD;
                        end
                    end
                    PH_LEAD, PH_HIGH:
                    begin
                        if (reached)
                        begin
                            phase_next = (phase_reg == PH_LEAD) ? PH_HIGH : PH_LOW;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[CNT_W-1:0];
                        end
                    end
                    PH_LOW:
                    begin
                        if (reached)
                        begin
                            cnt_next = '0;
                            if (bit_pos_reg != LAST_BIT_POS)
                            begin
                                bit_pos_next = bit_pos_reg + 1'b1;
                                phase_next   = PH_HIGH;
                            end
                            else if (cur_last_reg)
                            begin
                                phase_next = PH_RESET;
                            end
                            else if (held_valid_reg)
                            begin
                                shift_next      = held_byte_reg;
                                cur_last_next   = held_last_reg;
                                held_valid_next = 1'b0;
                                bit_pos_next    = '0;
                                phase_next      = PH_HIGH;
                            end
                            else
                            begin
                                phase_next = PH_WAIT;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_inc[CNT_W-1:0];
                        end
                    end
                    PH_WAIT:
                    begin
                        if (held_valid_reg)
                        begin
                            shift_next      = held_byte_reg;
                            cur_last_next   = held_last_reg;
                            held_valid_next = 1'b0;
                            bit_pos_next    = '0;
                            cnt_next        = '0;
                            phase_next      = PH_HIGH;
                        end
                    end
                    PH_RESET:
                    begin
                        if (reached)
                        begin
                            phase_next = PH_IDLE;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[CNT_W-1:0];
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                endcase
            end
        end
    end

    // Outputs
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (head_pop)
        begin
            out_valid_next              = 1'b1;
            out_res_next.pin_level      = (phase_next == PH_HIGH);
            out_res_next.byte_accepted  = !is_tick && !held_valid_reg;
            out_res_next.holding_free   = !held_valid_next;
            out_res_next.frame_done     = is_tick && (phase_reg == PH_RESET) && reached;
            out_res_next.busy_res       = (phase_next != PH_IDLE);
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            cnt_reg        <= '0;
            shift_reg      <= '0;
            bit_pos_reg    <= '0;
            cur_last_reg   <= 1'b0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            shift_reg      <= shift_next;
            bit_pos_reg    <= bit_pos_next;
            cur_last_reg   <= cur_last_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_last_reg  <= held_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pin_level     = out_res_reg.pin_level;
    assign out_ch.byte_accepted = out_res_reg.byte_accepted;
    assign out_ch.holding_free  = out_res_reg.holding_free;
    assign out_ch.frame_done    = out_res_reg.frame_done;
    assign out_ch.busy_res      = out_res_reg.busy_res;

endmodule

// ===== rtl/single_wire_led_bit_serializer_top.sv =====
// A request waits in the request queue, and its result is registered in the engine's
// output slot; a stalled output holds later requests in the queue.
// Throughput: one request per cycle unless the output stalls; a tick request moves the
// engine's waveform state machine by one step; the request queue absorbs stalls.
// Reset: rst_n clears the queue, the waveform state and the holding register, and
// returns the timing registers to their default values.
module single_wire_led_bit_serializer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    swled_in_if.sink                            in_ch,
    swled_out_if.source                         out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swled_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [swled_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swled_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import swled_pkg::*;

    logic [SHORT_W-1:0]   one_high_reg;
    logic [SHORT_W-1:0]   one_low_reg;
    logic [SHORT_W-1:0]   zero_high_reg;
    logic [SHORT_W-1:0]   zero_low_reg;
    logic [LONG_W-1:0]    reset_reg;
    logic [LONG_W-1:0]    lead_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    timing_t              timing;
    logic                 head_valid;
    req_t                 head_req;
    logic                 head_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= ONE_HIGH_RST;
            one_low_reg   <= ONE_LOW_RST;
            zero_high_reg <= ZERO_HIGH_RST;
            zero_low_reg  <= ZERO_LOW_RST;
            reset_reg     <= RESET_RST;
            lead_reg      <= LEAD_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ONE_HIGH:  one_high_reg  <= pwdata[SHORT_W-1:0];
                REG_ONE_LOW:   one_low_reg   <= pwdata[SHORT_W-1:0];
                REG_ZERO_HIGH: zero_high_reg <= pwdata[SHORT_W-1:0];
                REG_ZERO_LOW:  zero_low_reg  <= pwdata[SHORT_W-1:0];
                REG_RESET:     reset_reg     <= pwdata[LONG_W-1:0];
                REG_LEAD:      lead_reg      <= pwdata[LONG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back timing registers
    always_comb
    begin
        case (reg_idx)
            REG_ONE_HIGH:  prdata = APB_DATA_W'(one_high_reg);
            REG_ONE_LOW:   prdata = APB_DATA_W'(one_low_reg);
            REG_ZERO_HIGH: prdata = APB_DATA_W'(zero_high_reg);
            REG_ZERO_LOW:  prdata = APB_DATA_W'(zero_low_reg);
            REG_RESET:     prdata = APB_DATA_W'(reset_reg);
            REG_LEAD:      prdata = APB_DATA_W'(lead_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        timing.one_high_ticks  = one_high_reg;
        timing.one_low_ticks   = one_low_reg;
        timing.zero_high_ticks = zero_high_reg;
        timing.zero_low_ticks  = zero_low_reg;
        timing.reset_ticks     = reset_reg;
        timing.lead_ticks      = lead_reg;
    end

    swled_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .head_valid (head_valid),
        .head_req   (head_req),
        .head_pop   (head_pop)
    );

    swled_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .timing     (timing),
        .head_valid (head_valid),
        .head_req   (head_req),
        .head_pop   (head_pop),
        .out_ch     (out_ch)
    );

endmodule
